[hw/rtl/oja_pkg.sv]
// Shared types and constants of the objective and gradient engine.
`timescale 1ns / 1ps
`default_nettype none
package oja_pkg;

	localparam int WORD_W       = 32;
	localparam int PLANE_SLOT_W = 8;
	localparam int TERM_SLOT_W  = 4;
	localparam int COMP_W       = 3;
	localparam int VAL_W        = 48;
	localparam int DIV_W        = 64;

	localparam int DIMS_W   = 4;
	localparam int PLANES_W = 9;
	localparam int APB_W    = 32;
	localparam int PADDR_W  = 4;

	localparam logic [DIMS_W-1:0] DIMS_RST = 4'd2;

	localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] G64_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] G64_MIN = 64'shFFFF_8000_0000_0000;
	localparam logic [VAL_W-1:0]   OBJ_MAX = 48'hFFFF_FFFF_FFFF;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_POINT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_DIMS   = 2'd0,
		REG_PLANES = 2'd1,
		REG_RANK   = 2'd2
	} reg_t;

	typedef struct packed {
		logic load_wr;
		logic point_wr;
		logic walk_clr;
		logic rd;
		logic rd_first;
		logic rd_last;
		logic plane_adv;
		logic div_start;
		logic sel_obj;
		logic out_load;
		logic out_last;
	} ctrl_t;

	typedef struct packed {
		logic pipe_busy;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

[hw/rtl/oja_in_if.sv]
// Input channel: coefficient loads and query coordinates.
`timescale 1ns / 1ps
`default_nettype none
interface oja_in_if;
	import oja_pkg::*;

	logic                           valid;
	logic                           ready;
	cmd_t                           cmd;
	logic [PLANE_SLOT_W-1:0]        plane_slot;
	logic [TERM_SLOT_W-1:0]         term_slot;
	logic signed [WORD_W-1:0]       word;

	modport source (output valid, cmd, plane_slot, term_slot, word, input ready);
	modport sink (input valid, cmd, plane_slot, term_slot, word, output ready);
endinterface
`default_nettype wire

[hw/rtl/oja_out_if.sv]
// Result channel: one gradient or rank component per word.
`timescale 1ns / 1ps
`default_nettype none
interface oja_out_if;
	import oja_pkg::*;

	logic                           valid;
	logic                           ready;
	logic [COMP_W-1:0]              component;
	logic signed [VAL_W-1:0]        grad_value;
	logic [VAL_W-1:0]               objective;
	logic                           last;

	modport source (output valid, component, grad_value, objective, last, input ready);
	modport sink (input valid, component, grad_value, objective, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/oja_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module oja_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2304
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]                rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[hw/rtl/oja_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module oja_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [oja_pkg::DIV_W-1:0]  dividend,
	input  wire logic [oja_pkg::DIV_W-1:0]  divisor,
	output logic                            done,
	output logic [oja_pkg::DIV_W-1:0]       quotient
);
	import oja_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W:0]   shl_c;
	logic [DIV_W:0]   diff_c;
	logic             ge_c;

	always_comb begin
		shl_c  = {rem_q, quo_q[DIV_W-1]};
		diff_c = shl_c - {1'b0, div_q};
		ge_c   = !diff_c[DIV_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge_c ? diff_c[DIV_W-1:0] : shl_c[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge_c};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

[hw/rtl/oja_ctrl.sv]
// Sequencer: input decode, plane walk, division order and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module oja_ctrl #(
	parameter int DIM_MAX    = 8,
	parameter int PLANES_MAX = 256
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	oja_in_if.sink                                              item,
	input  wire logic [$clog2(DIM_MAX+1)-1:0]                   dim,
	input  wire logic [$clog2(PLANES_MAX+1)-1:0]                planes,
	input  oja_pkg::stat_t                                      stat,
	output oja_pkg::ctrl_t                                      ctrl,
	output logic [$clog2(DIM_MAX+1)-1:0]                        term_idx,
	output logic [((DIM_MAX > 1) ? $clog2(DIM_MAX) : 1)-1:0]    comp_idx
);
	import oja_pkg::*;

	localparam int TW = $clog2(DIM_MAX + 1);
	localparam int PW = $clog2(PLANES_MAX + 1);
	localparam int KW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_DSTART,
		S_DRUN,
		S_EMIT
	} state_t;

	state_t        state_q;
	logic [TW-1:0] t_q;
	logic [PW-1:0] p_q;
	logic [KW-1:0] k_q;
	logic          obj_phase_q;

	logic accept_c;
	logic is_point_c;
	logic load_ok_c;
	logic point_ok_c;
	logic fire_c;
	logic t_end_c;
	logic p_end_c;
	logic k_end_c;

	assign item.ready = (state_q == S_IDLE);

	always_comb begin
		accept_c   = item.valid && item.ready;
		is_point_c = (item.cmd == CMD_POINT);
		load_ok_c  = (32'(item.term_slot) <= 32'(DIM_MAX)) &&
			(32'(item.plane_slot) < 32'(PLANES_MAX));
		point_ok_c = (item.term_slot != '0) && (32'(item.term_slot) <= 32'(dim));
		fire_c     = accept_c && is_point_c && point_ok_c &&
			(32'(item.term_slot) == 32'(dim));
		t_end_c    = (t_q == dim);
		p_end_c    = (32'(p_q) + 32'd1 == 32'(planes));
		k_end_c    = (32'(k_q) + 32'd1 == 32'(dim));
	end

	always_comb begin
		ctrl           = '0;
		ctrl.load_wr   = accept_c && !is_point_c && load_ok_c;
		ctrl.point_wr  = accept_c && is_point_c && point_ok_c;
		ctrl.walk_clr  = fire_c;
		ctrl.rd        = (state_q == S_WALK);
		ctrl.rd_first  = (t_q == '0);
		ctrl.rd_last   = t_end_c;
		ctrl.plane_adv = (state_q == S_WALK) && t_end_c;
		ctrl.div_start = (state_q == S_DSTART);
		ctrl.sel_obj   = obj_phase_q;
		ctrl.out_load  = (state_q == S_EMIT) && stat.out_free;
		ctrl.out_last  = k_end_c;
	end

	assign term_idx = t_q;
	assign comp_idx = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			t_q         <= '0;
			p_q         <= '0;
			k_q         <= '0;
			obj_phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fire_c) begin
						t_q     <= '0;
						p_q     <= '0;
						state_q <= (planes == '0) ? S_DRAIN : S_WALK;
					end
				end
				S_WALK: begin
					if (t_end_c) begin
						t_q <= '0;
						p_q <= p_q + 1'b1;
						if (p_end_c) begin
							state_q <= S_DRAIN;
						end
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						obj_phase_q <= 1'b1;
						k_q         <= '0;
						state_q     <= S_DSTART;
					end
				end
				S_DSTART: begin
					state_q <= S_DRUN;
				end
				S_DRUN: begin
					if (stat.div_done) begin
						if (obj_phase_q) begin
							obj_phase_q <= 1'b0;
							state_q     <= S_DSTART;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						if (k_end_c) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_DSTART;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[hw/rtl/oja_dp.sv]
// Datapath: coefficient store, multiply-accumulate pipeline, sums, divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module oja_dp #(
	parameter int DIM_MAX    = 8,
	parameter int PLANES_MAX = 256
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  oja_pkg::ctrl_t                                          ctrl,
	output oja_pkg::stat_t                                          stat,
	input  wire logic [$clog2(DIM_MAX+1)-1:0]                       dim,
	input  wire logic [$clog2(PLANES_MAX+1)-1:0]                    planes,
	input  wire logic                                               rank,
	input  wire logic [$clog2(DIM_MAX+1)-1:0]                       term_idx,
	input  wire logic [((DIM_MAX > 1) ? $clog2(DIM_MAX) : 1)-1:0]   comp_idx,
	input  wire logic [oja_pkg::PLANE_SLOT_W-1:0]                   plane_slot,
	input  wire logic [oja_pkg::TERM_SLOT_W-1:0]                    term_slot,
	input  wire logic signed [oja_pkg::WORD_W-1:0]                  word,
	oja_out_if.source                                               result
);
	import oja_pkg::*;

	localparam int TERMS = DIM_MAX + 1;
	localparam int TW    = $clog2(DIM_MAX + 1);
	localparam int KW    = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
	localparam int AW    = $clog2(PLANES_MAX * TERMS);
	localparam int GW    = WORD_W + $clog2(PLANES_MAX + 1);

	function automatic logic [DIV_W-1:0] factorial(input int n);
		logic [DIV_W-1:0] f;
		f = DIV_W'(1);
		for (int i = 2; i <= n; i++) begin
			f = f * DIV_W'(i);
		end
		return f;
	endfunction

	logic [DIV_W-1:0] fact_tbl [DIM_MAX+1];

	for (genvar g = 0; g <= DIM_MAX; g++) begin : g_fact
		assign fact_tbl[g] = factorial(g);
	end

	logic [AW-1:0]              base_q;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              rd_addr;
	logic [WORD_W-1:0]          ram_rdata;

	logic                       v_s1;
	logic                       first_s1;
	logic                       last_s1;
	logic [TW-1:0]              t_s1;
	logic [KW-1:0]              t_idx_c;
	logic signed [WORD_W-1:0]   coef_c;
	logic signed [WORD_W-1:0]   x_c;
	logic signed [63:0]         prod_c;
	logic signed [63:0]         const_c;

	logic                       v_s2;
	logic                       first_s2;
	logic                       last_s2;
	logic signed [63:0]         prod_s2;
	logic signed [63:0]         acc_q;
	logic signed [63:0]         sum_c;
	logic                       ovf_c;
	logic signed [63:0]         acc_c;

	logic                       v_s3;
	logic signed [63:0]         s_s3;
	logic [63:0]                mag_c;

	logic signed [WORD_W-1:0]   qp_q    [DIM_MAX];
	logic signed [WORD_W-1:0]   nbuf_q  [DIM_MAX];
	logic signed [WORD_W-1:0]   nhold_q [DIM_MAX];
	logic signed [GW-1:0]       grad_q  [DIM_MAX];
	logic [63:0]                abs_sum_q;

	logic signed [GW-1:0]       gsel_c;
	logic [GW-1:0]              gmag_c;
	logic [DIV_W-1:0]           div_a;
	logic [DIV_W-1:0]           div_b;
	logic [DIV_W-1:0]           quo;
	logic                       div_done;
	logic                       neg_q;
	logic signed [63:0]         gq_c;
	logic [VAL_W-1:0]           obj_q;
	logic signed [VAL_W-1:0]    gres_q;

	logic                       out_v_q;
	logic [COMP_W-1:0]          comp_q;
	logic signed [VAL_W-1:0]    grad_out_q;
	logic [VAL_W-1:0]           obj_out_q;
	logic                       last_q;

	assign wr_addr = AW'(32'(plane_slot) * 32'(TERMS) + 32'(term_slot));
	assign rd_addr = base_q + AW'(term_idx);

	oja_ram #(
		.WIDTH(WORD_W),
		.DEPTH(PLANES_MAX * TERMS)
	) u_ram (
		.clk   (clk),
		.we    (ctrl.load_wr),
		.waddr (wr_addr),
		.wdata (word),
		.re    (ctrl.rd),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		t_idx_c = KW'(t_s1 - 1'b1);
		coef_c  = ram_rdata;
		x_c     = qp_q[t_idx_c];
		prod_c  = coef_c * x_c;
		const_c = {{16{ram_rdata[WORD_W-1]}}, ram_rdata, 16'h0000};
	end

	always_comb begin
		sum_c = acc_q + prod_s2;
		ovf_c = (acc_q[63] == prod_s2[63]) && (sum_c[63] != acc_q[63]);
		if (first_s2) begin
			acc_c = prod_s2;
		end else if (ovf_c) begin
			acc_c = prod_s2[63] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_c = sum_c;
		end
		mag_c = s_s3[63] ? (~s_s3 + 64'd1) : s_s3;
	end

	always_comb begin
		gsel_c = grad_q[comp_idx];
		gmag_c = gsel_c[GW-1] ? GW'(-gsel_c) : GW'(gsel_c);
		div_a  = ctrl.sel_obj ? abs_sum_q : DIV_W'(gmag_c);
		div_b  = (ctrl.sel_obj || !rank) ? fact_tbl[dim] : DIV_W'(planes);
		gq_c   = neg_q ? -$signed(quo) : $signed(quo);
	end

	oja_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= ctrl.rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
			if (ctrl.out_load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= ctrl.rd_first;
		last_s1  <= ctrl.rd_last;
		t_s1     <= term_idx;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= first_s1 ? const_c : prod_c;

		if (ctrl.walk_clr) begin
			base_q <= '0;
		end else if (ctrl.plane_adv) begin
			base_q <= base_q + AW'(TERMS);
		end

		if (ctrl.point_wr) begin
			qp_q[KW'(term_slot - 1'b1)] <= word;
		end

		if (v_s1 && !first_s1) begin
			nbuf_q[t_idx_c] <= ram_rdata;
		end

		if (v_s2) begin
			acc_q <= acc_c;
		end
		if (v_s2 && last_s2) begin
			s_s3    <= acc_c;
			nhold_q <= nbuf_q;
		end

		if (ctrl.walk_clr) begin
			abs_sum_q <= '0;
			for (int i = 0; i < DIM_MAX; i++) begin
				grad_q[i] <= '0;
			end
		end else if (v_s3) begin
			abs_sum_q <= abs_sum_q + {16'h0000, mag_c[63:16]};
			if (s_s3 != '0) begin
				for (int i = 0; i < DIM_MAX; i++) begin
					grad_q[i] <= s_s3[63] ? grad_q[i] - GW'(nhold_q[i]) :
						grad_q[i] + GW'(nhold_q[i]);
				end
			end
		end

		if (ctrl.div_start) begin
			neg_q <= !ctrl.sel_obj && gsel_c[GW-1];
		end

		if (div_done) begin
			if (ctrl.sel_obj) begin
				if (rank) begin
					obj_q <= '0;
				end else if (quo[DIV_W-1:VAL_W] != '0) begin
					obj_q <= OBJ_MAX;
				end else begin
					obj_q <= quo[VAL_W-1:0];
				end
			end else begin
				if (rank && planes == '0) begin
					gres_q <= '0;
				end else if (gq_c > G64_MAX) begin
					gres_q <= G64_MAX[VAL_W-1:0];
				end else if (gq_c < G64_MIN) begin
					gres_q <= G64_MIN[VAL_W-1:0];
				end else begin
					gres_q <= gq_c[VAL_W-1:0];
				end
			end
		end

		if (ctrl.out_load) begin
			comp_q     <= COMP_W'(comp_idx);
			grad_out_q <= gres_q;
			obj_out_q  <= obj_q;
			last_q     <= ctrl.out_last;
		end
	end

	assign stat.pipe_busy = v_s1 || v_s2 || v_s3;
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_v_q || result.ready;

	assign result.valid      = out_v_q;
	assign result.component  = comp_q;
	assign result.grad_value = grad_out_q;
	assign result.objective  = obj_out_q;
	assign result.last       = last_q;
endmodule
`default_nettype wire

[hw/rtl/oja_objective_and_gradient.sv]
// Top level: configuration registers, sequencer and datapath of the objective and gradient engine.
//
// Usage. Configure over the APB port while idle: dims_in_use at 0x0, plane_count
// at 0x4, rank_mode at 0x8. Load plane coefficients through the item channel
// (cmd load, plane_slot, term_slot 0 for the constant, k for normal k), then
// send the query coordinates 1..d. The last coordinate starts an evaluation:
// the walk reads one coefficient per cycle from the coefficient RAM for each
// of the N planes, then the multiply-accumulate pipeline drains. A shared
// radix-2 divider then runs d+1 divisions (objective first, then one per
// component); after each component division the result word is loaded into
// the output register as soon as that register is free. The item channel stays
// not ready until the last result word sits in the output register.
// The result channel holds its word while ready is low; the next division runs
// meanwhile and waits for the output register to free up.
// Reset (arst_n low) clears control state and loads dims_in_use 2,
// plane_count 0, rank_mode 0; coefficient and point stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module oja_objective_and_gradient #(
	parameter int DIM_MAX    = 8,
	parameter int PLANES_MAX = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	oja_in_if.sink                              item,
	oja_out_if.source                           result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [oja_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [oja_pkg::APB_W-1:0]      pwdata,
	output logic [oja_pkg::APB_W-1:0]           prdata,
	output logic                                pready
);
	import oja_pkg::*;

	localparam int TW = $clog2(DIM_MAX + 1);
	localparam int PW = $clog2(PLANES_MAX + 1);
	localparam int KW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

	logic [DIMS_W-1:0]   dims_q;
	logic [PLANES_W-1:0] pcount_q;
	logic                rank_q;
	reg_t                reg_idx;
	logic [TW-1:0]       dim_c;
	logic [PW-1:0]       np_c;

	ctrl_t               ctrl;
	stat_t               stat;
	logic [TW-1:0]       term_idx;
	logic [KW-1:0]       comp_idx;

	assign reg_idx = reg_t'(paddr[PADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q   <= DIMS_RST;
			pcount_q <= '0;
			rank_q   <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_DIMS:   dims_q   <= pwdata[DIMS_W-1:0];
				REG_PLANES: pcount_q <= pwdata[PLANES_W-1:0];
				REG_RANK:   rank_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DIMS:   prdata = APB_W'(dims_q);
			REG_PLANES: prdata = APB_W'(pcount_q);
			REG_RANK:   prdata = APB_W'(rank_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		if (dims_q == '0) begin
			dim_c = TW'(1);
		end else if ({1'b0, dims_q} > (DIMS_W+1)'(DIM_MAX)) begin
			dim_c = TW'(DIM_MAX);
		end else begin
			dim_c = TW'(dims_q);
		end
		np_c = (32'(pcount_q) > 32'(PLANES_MAX)) ? PW'(PLANES_MAX) : PW'(pcount_q);
	end

	oja_ctrl #(
		.DIM_MAX    (DIM_MAX),
		.PLANES_MAX (PLANES_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.dim      (dim_c),
		.planes   (np_c),
		.stat     (stat),
		.ctrl     (ctrl),
		.term_idx (term_idx),
		.comp_idx (comp_idx)
	);

	oja_dp #(
		.DIM_MAX    (DIM_MAX),
		.PLANES_MAX (PLANES_MAX)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.dim        (dim_c),
		.planes     (np_c),
		.rank       (rank_q),
		.term_idx   (term_idx),
		.comp_idx   (comp_idx),
		.plane_slot (item.plane_slot),
		.term_slot  (item.term_slot),
		.word       (item.word),
		.result     (result)
	);
endmodule
`default_nettype wire

[tb/tb_oja_objective_and_gradient.sv]
// Self-checking testbench of the objective and gradient engine with its own Q16.16 predictor.
`timescale 1ns / 1ps
module tb_oja_objective_and_gradient;
	import oja_pkg::*;

	typedef struct packed {
		logic [COMP_W-1:0] component;
		logic [VAL_W-1:0]  grad_value;
		logic [VAL_W-1:0]  objective;
		logic              last;
	} grad_word_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_W-1:0] pwdata;
	logic [APB_W-1:0] prdata;
	logic pready;

	oja_in_if item_bus ();
	oja_out_if result_bus ();

	oja_objective_and_gradient dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic signed [WORD_W-1:0] plane_coef [256][9];
	logic signed [WORD_W-1:0] point_coord [8];
	logic [3:0] dims_reg = DIMS_RST;
	logic [8:0] planes_reg = 9'd0;
	logic rank_reg = 1'b0;

	grad_word_t pending_gradients [$];
	grad_word_t expected_word;

	bit sender_gaps = 1'b0;
	bit receiver_stalls = 1'b0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	int unsigned mismatch_count = 0;
	int unsigned words_checked = 0;
	int unsigned loads_sent = 0;
	int unsigned coords_sent = 0;
	int unsigned useful_items = 0;
	int unsigned register_writes = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Verification failed");
		$finish;
	end

	function automatic int unsigned eff_dims();
		if (dims_reg == 4'd0) begin
			return 1;
		end
		if (dims_reg > 4'd8) begin
			return 8;
		end
		return dims_reg;
	endfunction

	function automatic int unsigned eff_planes();
		if (planes_reg > 9'd256) begin
			return 256;
		end
		return planes_reg;
	endfunction

	function automatic longint sat_acc(longint a, longint b);
		logic [64:0] w;
		w = {a[63], a} + {b[63], b};
		if (w[64] != w[63]) begin
			return w[64] ? ACC_MIN : ACC_MAX;
		end
		return w[63:0];
	endfunction

	function automatic logic [VAL_W-1:0] sat_grad(longint v);
		if (v > G64_MAX) begin
			return G64_MAX[VAL_W-1:0];
		end
		if (v < G64_MIN) begin
			return G64_MIN[VAL_W-1:0];
		end
		return v[VAL_W-1:0];
	endfunction

	function automatic void predict_gradients();
		int unsigned d;
		int unsigned np;
		longint s;
		longint n;
		longint fact;
		longint grad_sum [8];
		bit [63:0] mag;
		bit [63:0] abs_sum;
		bit [63:0] obj;
		grad_word_t gw;
		d = eff_dims();
		np = eff_planes();
		fact = 1;
		abs_sum = 0;
		for (int k = 1; k <= d; k++) begin
			fact = fact * k;
		end
		for (int k = 0; k < 8; k++) begin
			grad_sum[k] = 0;
		end
		for (int p = 0; p < np; p++) begin
			s = longint'(plane_coef[p][0]) * 65536;
			for (int k = 0; k < d; k++) begin
				s = sat_acc(s, longint'(plane_coef[p][k+1]) * longint'(point_coord[k]));
			end
			mag = (s < 0) ? -s : s;
			abs_sum = abs_sum + (mag >> 16);
			if (s != 0) begin
				for (int k = 0; k < d; k++) begin
					n = longint'(plane_coef[p][k+1]);
					grad_sum[k] = grad_sum[k] + ((s > 0) ? n : -n);
				end
			end
		end
		if (rank_reg) begin
			obj = 0;
			for (int k = 0; k < d; k++) begin
				grad_sum[k] = (np == 0) ? 0 : grad_sum[k] / longint'(np);
			end
		end else begin
			obj = abs_sum / 64'(fact);
			if (obj > 64'h0000_FFFF_FFFF_FFFF) begin
				obj = 64'h0000_FFFF_FFFF_FFFF;
			end
			for (int k = 0; k < d; k++) begin
				grad_sum[k] = grad_sum[k] / fact;
			end
		end
		for (int k = 0; k < d; k++) begin
			gw.component = k[COMP_W-1:0];
			gw.grad_value = sat_grad(grad_sum[k]);
			gw.objective = obj[VAL_W-1:0];
			gw.last = (k + 1 == d);
			pending_gradients.insert(pending_gradients.size(), gw);
		end
	endfunction

	function automatic bit apply_item(cmd_t c, logic [7:0] plane, logic [3:0] term,
			logic signed [WORD_W-1:0] value);
		int unsigned d;
		d = eff_dims();
		if (c == CMD_LOAD) begin
			if (term > 4'd8) begin
				return 1'b0;
			end
			plane_coef[plane][term] = value;
			return 1'b1;
		end
		if (term < 4'd1 || term > d) begin
			return 1'b0;
		end
		point_coord[term-1] = value;
		if (term == d) begin
			predict_gradients();
		end
		return 1'b1;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3, 4, 5: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		if (result_bus.valid && result_bus.ready) begin
			words_checked++;
			if (pending_gradients.size() == 0) begin
				$display("%0t: result word with nothing expected: component %0d grad %0h obj %0h last %0b",
					$time, result_bus.component, result_bus.grad_value, result_bus.objective,
					result_bus.last);
				mismatch_count++;
			end else begin
				expected_word = pending_gradients.pop_front();
				if (result_bus.component !== expected_word.component) begin
					$display("%0t: component expected %0d, got %0d", $time,
						expected_word.component, result_bus.component);
					mismatch_count++;
				end
				if (result_bus.grad_value !== expected_word.grad_value) begin
					$display("%0t: grad_value expected %0h, got %0h", $time,
						expected_word.grad_value, result_bus.grad_value);
					mismatch_count++;
				end
				if (result_bus.objective !== expected_word.objective) begin
					$display("%0t: objective expected %0h, got %0h", $time,
						expected_word.objective, result_bus.objective);
					mismatch_count++;
				end
				if (result_bus.last !== expected_word.last) begin
					$display("%0t: last expected %0b, got %0b", $time,
						expected_word.last, result_bus.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_bus.ready = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result_bus.ready = 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				result_bus.ready = 1'b0;
			end else begin
				result_bus.ready = 1'b1;
			end
		end
	end

	task automatic write_register(reg_t r, logic [APB_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {r, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (r)
			REG_DIMS: dims_reg = value[3:0];
			REG_PLANES: planes_reg = value[8:0];
			REG_RANK: rank_reg = value[0];
			default: ;
		endcase
		register_writes++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic configure(logic [3:0] dims, logic [8:0] planes, logic rank);
		write_register(REG_DIMS, 32'(dims));
		write_register(REG_PLANES, 32'(planes));
		write_register(REG_RANK, 32'(rank));
	endtask

	task automatic send_item(cmd_t c, logic [7:0] plane, logic [3:0] term,
			logic [WORD_W-1:0] value);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				item_bus.valid = 1'b0;
			end
		end
		@(negedge clk);
		item_bus.cmd = c;
		item_bus.plane_slot = plane;
		item_bus.term_slot = term;
		item_bus.word = value;
		item_bus.valid = 1'b1;
		do @(posedge clk); while (!item_bus.ready);
		if (apply_item(c, plane, term, value)) begin
			useful_items++;
		end
		if (c == CMD_LOAD) begin
			loads_sent++;
		end else begin
			coords_sent++;
		end
	endtask

	task automatic send_point(logic [WORD_W-1:0] x1, logic [WORD_W-1:0] rest);
		int unsigned d;
		d = eff_dims();
		for (int k = 1; k <= d; k++) begin
			send_item(CMD_POINT, 8'($urandom()), 4'(k), (k == 1) ? x1 : rest);
		end
	endtask

	// drop valid and hold until every result word has been taken
	task automatic settle();
		@(negedge clk);
		item_bus.valid = 1'b0;
		while (pending_gradients.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		settle();
	endtask

	task automatic test_full_store();
		configure(4'd8, 9'd256, 1'b0);
		for (int p = 0; p < 256; p++) begin
			for (int t = 0; t <= 8; t++) begin
				send_item(CMD_LOAD, 8'(p), 4'(t), pick_word());
			end
		end
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		settle();
		write_register(REG_PLANES, 32'd511);
		send_point(32'h0001_0000, 32'hFFFF_8000);
		settle();
		write_register(REG_RANK, 32'd1);
		send_point(32'h0000_0000, 32'h0002_0000);
		settle();
	endtask

	task automatic test_special_cases();
		configure(4'd2, 9'd3, 1'b0);
		send_item(CMD_LOAD, 8'd0, 4'd0, 32'h0001_0000);
		send_item(CMD_LOAD, 8'd0, 4'd1, 32'h0001_0000);
		send_item(CMD_LOAD, 8'd0, 4'd2, 32'h0000_0000);
		send_item(CMD_LOAD, 8'd1, 4'd0, 32'h0000_0000);
		send_item(CMD_LOAD, 8'd1, 4'd1, 32'h0000_0000);
		send_item(CMD_LOAD, 8'd1, 4'd2, 32'h0000_0000);
		send_item(CMD_LOAD, 8'd2, 4'd0, 32'h7FFF_FFFF);
		send_item(CMD_LOAD, 8'd2, 4'd1, 32'h8000_0000);
		send_item(CMD_LOAD, 8'd2, 4'd2, 32'h8000_0000);
		send_item(CMD_LOAD, 8'd255, 4'd9, 32'hDEAD_BEEF);
		send_item(CMD_LOAD, 8'd255, 4'd15, 32'h1234_5678);
		send_item(CMD_POINT, 8'd0, 4'd0, 32'h5555_5555);
		send_item(CMD_POINT, 8'd255, 4'd15, 32'hAAAA_AAAA);
		send_item(CMD_POINT, 8'd7, 4'd1, 32'hFFFF_0000);
		send_item(CMD_POINT, 8'd7, 4'd2, 32'h0000_0000);
		send_point(32'h8000_0000, 32'h8000_0000);
		settle();
		write_register(REG_RANK, 32'd1);
		send_item(CMD_POINT, 8'd0, 4'd2, 32'h7FFF_FFFF);
		settle();
		write_register(REG_PLANES, 32'd0);
		send_item(CMD_POINT, 8'd0, 4'd2, 32'h0001_0000);
		settle();
	endtask

	task automatic test_saturation();
		configure(4'd2, 9'd8, 1'b0);
		for (int p = 0; p < 8; p++) begin
			for (int t = 0; t <= 2; t++) begin
				send_item(CMD_LOAD, 8'(p), 4'(t), 32'h8000_0000);
			end
		end
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		settle();
	endtask

	task automatic test_dimension_clamp();
		configure(4'd0, 9'd4, 1'b0);
		send_item(CMD_POINT, 8'd0, 4'd2, 32'h0003_0000);
		send_item(CMD_POINT, 8'd0, 4'd1, 32'hFFFE_0000);
		settle();
		write_register(REG_DIMS, 32'd15);
		send_point(32'h0000_8000, 32'hFFFF_C000);
		settle();
		write_register(REG_DIMS, 32'd9);
		send_point(32'h7FFF_FFFF, 32'h0001_0000);
		settle();
		write_register(REG_DIMS, 32'd1);
		send_point(32'h0004_0000, 32'h0);
		settle();
	endtask

	task automatic test_backpressure();
		configure(4'd3, 9'd8, 1'b0);
		sender_gaps = 1'b0;
		hold_request = 1500;
		repeat (3) begin
			send_point(pick_word(), pick_word());
		end
		settle();
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		int unsigned d;
		int unsigned np;
		int unsigned start;
		int unsigned mark;
		int unsigned phase_left;
		int unsigned r;
		int order [8];
		int tmp;
		int j;
		start = useful_items;
		phase_left = 0;
		while (useful_items - start < 280) begin
			if (phase_left == 0) begin
				settle();
				r = $urandom_range(0, 19);
				configure(($urandom_range(0, 9) == 0) ?
						($urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15))) :
						4'($urandom_range(1, 8)),
					(r == 0) ? 9'd0 : (r == 1) ? 9'($urandom_range(256, 511)) :
						(r < 5) ? 9'($urandom_range(17, 64)) : 9'($urandom_range(1, 16)),
					1'($urandom_range(0, 1)));
				phase_left = $urandom_range(25, 45);
			end
			if (useful_items - start >= 220) begin
				sender_gaps = 1'b0;
				receiver_stalls = 1'b0;
			end
			d = eff_dims();
			np = eff_planes();
			mark = useful_items;
			if ($urandom_range(0, 2) == 0) begin
				send_item(CMD_LOAD,
					(np == 0 || $urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(0, np - 1)),
					($urandom_range(0, 11) == 0) ? 4'($urandom_range(9, 15)) :
						4'($urandom_range(0, d)),
					pick_word());
			end else begin
				for (int i = 0; i + 1 < d; i++) begin
					order[i] = i + 1;
				end
				for (int i = d - 2; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
				for (int i = 0; i + 1 < d; i++) begin
					if ($urandom_range(0, 3) != 0) begin
						send_item(CMD_POINT, 8'($urandom()), 4'(order[i]), pick_word());
					end
				end
				if ($urandom_range(0, 7) == 0) begin
					send_item(CMD_POINT, 8'($urandom()),
						$urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(d + 1, 15)), pick_word());
				end
				if ($urandom_range(0, 9) != 0) begin
					send_item(CMD_POINT, 8'($urandom()), 4'(d), pick_word());
				end
			end
			phase_left = (phase_left > useful_items - mark) ? phase_left - (useful_items - mark) : 0;
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_bus.valid = 1'b0;
		item_bus.cmd = CMD_LOAD;
		item_bus.plane_slot = '0;
		item_bus.term_slot = '0;
		item_bus.word = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		test_reset_state();
		test_full_store();
		test_special_cases();
		test_saturation();
		test_dimension_clamp();
		test_backpressure();
		test_random_traffic();
		repeat (700) @(posedge clk);
		if (pending_gradients.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, pending_gradients.size());
			mismatch_count++;
		end
		$display("Run covered %0d coefficient loads, %0d query coordinates and %0d register writes,",
			loads_sent, coords_sent, register_writes);
		$display("with %0d result words checked and %0d mismatches.", words_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
